/* design/crq_pkg.sv */
// ----------------------------------------------------------------------------
// crq_pkg
// shared types and constants for the corner row index rectangle query core
// ----------------------------------------------------------------------------
package crq_pkg;

    // default sizes
    localparam int MAX_CORNERS_DEF = 1024;
    localparam int MAX_ROWS_DEF    = 1024;
    localparam int MAX_HITS_DEF    = 63;

    // field widths
    localparam int COL_W  = 11;
    localparam int ROW_W  = 10;
    localparam int CIDX_W = 10;
    localparam int PT_W   = ROW_W + COL_W;

    // operation codes
    typedef logic [1:0] t_op;
    localparam t_op OP_CLEAR  = 2'd0;
    localparam t_op OP_APPEND = 2'd1;
    localparam t_op OP_QUERY  = 2'd2;

    typedef logic [CIDX_W-1:0] t_cidx;

    typedef struct packed {
        t_op              op;
        logic [COL_W-1:0] point_x;
        logic [ROW_W-1:0] point_y;
        logic [COL_W-1:0] box_w;
        logic [ROW_W-1:0] box_h;
    } t_in_item;

    typedef struct packed {
        t_cidx corner_index;
        logic  hit;
        logic  last;
        logic  truncated;
    } t_out_item;

    // result handed from the sequencer to the output register
    typedef struct packed {
        logic      load;
        t_out_item item;
    } t_emit;

endpackage

/* design/crq_ram.sv */
// ----------------------------------------------------------------------------
// crq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module crq_ram
    #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/crq_seq.sv */
// ----------------------------------------------------------------------------
// crq_seq
// sequencer: row table sweep, point append and row-by-row query walk
// ----------------------------------------------------------------------------
module crq_seq
    import crq_pkg::*;
    #(
    parameter int MAX_CORNERS = MAX_CORNERS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF,
    parameter int MAX_HITS    = MAX_HITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    output logic     o_in_rdy,
    input  logic     i_out_free,
    output t_emit    o_emit
);

    localparam int CW  = $clog2(MAX_CORNERS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int RCW = (RW + 1 > ROW_W) ? RW + 1 : ROW_W;
    localparam int HW  = $clog2(MAX_HITS + 1);

    typedef enum logic [6:0] {
        S_CLR   = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_ROW   = 7'b0000100,
        S_ROWRD = 7'b0001000,
        S_PTRD  = 7'b0010000,
        S_PTCHK = 7'b0100000,
        S_END   = 7'b1000000
    } t_state;

    t_state             r_state, n_state;
    logic [RW-1:0]      r_clr, n_clr;
    logic [CW:0]        r_count, n_count;
    logic [ROW_W-1:0]   r_prev_row, n_prev_row;
    logic               r_prev_vld, n_prev_vld;
    logic [RCW-1:0]     r_row, n_row;
    logic [COL_W-1:0]   r_x1, n_x1;
    logic [COL_W:0]     r_x2, n_x2;
    logic [COL_W-1:0]   r_y2, n_y2;
    logic [CW:0]        r_idx, n_idx;
    logic [HW-1:0]      r_hits, n_hits;
    logic               r_trunc, n_trunc;

    // row table: {present, start index}
    logic               row_we, row_re;
    logic [RW-1:0]      row_waddr, row_raddr;
    logic [CW:0]        row_wdata, row_rdata;
    // point store: {row, column}
    logic               pt_we, pt_re;
    logic [CW-1:0]      pt_waddr, pt_raddr;
    logic [PT_W-1:0]    pt_wdata, pt_rdata;

    logic [ROW_W-1:0]   pt_row;
    logic [COL_W-1:0]   pt_col;

    assign pt_row = pt_rdata[PT_W-1:COL_W];
    assign pt_col = pt_rdata[COL_W-1:0];

    crq_ram #(.WIDTH(CW + 1), .DEPTH(MAX_ROWS)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_re    (row_re),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    crq_ram #(.WIDTH(PT_W), .DEPTH(MAX_CORNERS)) u_pt_ram (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (pt_waddr),
        .i_wdata (pt_wdata),
        .i_re    (pt_re),
        .i_raddr (pt_raddr),
        .o_rdata (pt_rdata)
    );

    assign o_in_rdy = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_count    = r_count;
        n_prev_row = r_prev_row;
        n_prev_vld = r_prev_vld;
        n_row      = r_row;
        n_x1       = r_x1;
        n_x2       = r_x2;
        n_y2       = r_y2;
        n_idx      = r_idx;
        n_hits     = r_hits;
        n_trunc    = r_trunc;
        row_we     = 1'b0;
        row_waddr  = r_clr;
        row_wdata  = '0;
        row_re     = 1'b0;
        row_raddr  = r_row[RW-1:0];
        pt_we      = 1'b0;
        pt_waddr   = r_count[CW-1:0];
        pt_wdata   = {i_in_item.point_y, i_in_item.point_x};
        pt_re      = 1'b0;
        pt_raddr   = r_idx[CW-1:0];
        o_emit     = '0;

        case (r_state)
            S_CLR: begin
                row_we = 1'b1;
                if (32'(r_clr) == MAX_ROWS - 1) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_item.op)
                        OP_CLEAR: begin
                            n_count    = '0;
                            n_prev_vld = 1'b0;
                            n_clr      = '0;
                            n_state    = S_CLR;
                        end
                        OP_APPEND: begin
                            if (32'(r_count) < MAX_CORNERS &&
                                32'(i_in_item.point_y) < MAX_ROWS) begin
                                pt_we = 1'b1;
                                if (!r_prev_vld || i_in_item.point_y != r_prev_row) begin
                                    row_we     = 1'b1;
                                    row_waddr  = RW'(i_in_item.point_y);
                                    row_wdata  = {1'b1, r_count[CW-1:0]};
                                    n_prev_row = i_in_item.point_y;
                                    n_prev_vld = 1'b1;
                                end
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_QUERY: begin
                            n_x1    = i_in_item.point_x;
                            n_x2    = {1'b0, i_in_item.point_x} + {1'b0, i_in_item.box_w};
                            n_y2    = {1'b0, i_in_item.point_y} + {1'b0, i_in_item.box_h};
                            n_row   = RCW'(i_in_item.point_y);
                            n_hits  = '0;
                            n_trunc = 1'b0;
                            n_state = S_ROW;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ROW: begin
                if (32'(r_row) >= 32'(r_y2) || 32'(r_row) >= MAX_ROWS) begin
                    n_state = S_END;
                end else begin
                    row_re  = 1'b1;
                    n_state = S_ROWRD;
                end
            end
            S_ROWRD: begin
                if (row_rdata[CW]) begin
                    n_idx   = {1'b0, row_rdata[CW-1:0]};
                    n_state = S_PTRD;
                end else begin
                    n_row   = r_row + 1'b1;
                    n_state = S_ROW;
                end
            end
            S_PTRD: begin
                if (r_idx < r_count) begin
                    pt_re   = 1'b1;
                    n_state = S_PTCHK;
                end else begin
                    n_row   = r_row + 1'b1;
                    n_state = S_ROW;
                end
            end
            S_PTCHK: begin
                if (32'(pt_row) != 32'(r_row)) begin
                    n_row   = r_row + 1'b1;
                    n_state = S_ROW;
                end else if (pt_col < r_x1) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_PTRD;
                end else if ({1'b0, pt_col} < r_x2) begin
                    if (32'(r_hits) >= MAX_HITS) begin
                        n_trunc = 1'b1;
                        n_state = S_END;
                    end else if (i_out_free) begin
                        o_emit.load              = 1'b1;
                        o_emit.item.corner_index = t_cidx'(r_idx);
                        o_emit.item.hit          = 1'b1;
                        n_hits                   = r_hits + 1'b1;
                        n_idx                    = r_idx + 1'b1;
                        n_state                  = S_PTRD;
                    end
                end else begin
                    n_row   = r_row + 1'b1;
                    n_state = S_ROW;
                end
            end
            S_END: begin
                if (i_out_free) begin
                    o_emit.load           = 1'b1;
                    o_emit.item.last      = 1'b1;
                    o_emit.item.truncated = r_trunc;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr      <= '0;
            r_count    <= '0;
            r_prev_row <= '0;
            r_prev_vld <= 1'b0;
            r_hits     <= '0;
            r_trunc    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_count    <= n_count;
            r_prev_row <= n_prev_row;
            r_prev_vld <= n_prev_vld;
            r_hits     <= n_hits;
            r_trunc    <= n_trunc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_x1  <= n_x1;
        r_x2  <= n_x2;
        r_y2  <= n_y2;
        r_idx <= n_idx;
    end

endmodule

/* design/corner_row_index_rect_query_core.sv */
// ----------------------------------------------------------------------------
// corner_row_index_rect_query_core
// row-indexed corner point list with rectangle queries over the stored points
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake               payload
//  -------  ---  ----------------------  ---------------------------------
//  in       in   i_in_valid / o_in_stall   i_in_item  (op, point, box)
//  out      out  o_out_valid / i_out_stall o_out_item (index, hit, last, trunc)
//
//  append and unknown ops are taken without holding up the input; a clear op
//  is taken and then sweeps the row table with the input stalled
//  after reset the same row table sweep runs before the first item is taken
//  a query is taken, then reads the row table for each row visited and the
//  point store for each stored point examined; a row scan also ends when it
//  runs past the last stored point, and the query closes with a final row
//  check (or on reaching the hit cap) and the end marker
//  a stalled output holds the sequencer on the next result; items wait in
//  o_in_stall until the query's end marker is loaded
//
module corner_row_index_rect_query_core
    import crq_pkg::*;
    #(
    parameter int MAX_CORNERS = MAX_CORNERS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF,
    parameter int MAX_HITS    = MAX_HITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      in_rdy;
    logic      out_free;
    t_emit     emit;

    logic      r_out_valid, n_out_valid;
    t_out_item r_out_item;

    // output register can take a new item when empty or being drained
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !in_rdy;

    // sequencer owns the row table and point store
    crq_seq #(
        .MAX_CORNERS (MAX_CORNERS),
        .MAX_ROWS    (MAX_ROWS),
        .MAX_HITS    (MAX_HITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_rdy   (in_rdy),
        .i_out_free (out_free),
        .o_emit     (emit)
    );

    // output stage: one result item register
    always_comb begin
        n_out_valid = r_out_valid;
        if (emit.load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (emit.load) begin
            r_out_item <= emit.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef ASSERT_OFF
    // the sequencer must never overwrite a result that is still held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit.load |-> out_free)
        else $error("result loaded into a held output register");

    // after the end marker the block is ready for the next item
    a_ready_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit.load && emit.item.last) |=> in_rdy)
        else $error("not ready after end marker");

    // an accepted query keeps the input side stalled until its end marker
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && in_rdy && i_in_item.op == OP_QUERY) |=> !in_rdy)
        else $error("input taken while a query is running");

    // a hit result never carries the end flags
    a_hit_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit.load && emit.item.hit) |-> (!emit.item.last && !emit.item.truncated))
        else $error("hit result with end flags");
`endif

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the corner row index rectangle query core: a queue
// fed driver pushes clear, append, query and unknown items, a predictor keeps
// its own copy of the point list and row table and works out every hit and
// end marker, and a monitor compares each result with the oldest one due
// ----------------------------------------------------------------------------
module tb_top
    import crq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // idle cycles with no item moving on either side before giving up
    // (reset sweep, clear sweep, full-height query scan and the long hold-off
    // all fit many times over)
    localparam int WATCHDOG_LIMIT  = 20000;
    // wait after the last result, covers a trailing clear sweep
    localparam int DRAIN_CYCLES    = 2 * MAX_ROWS_DEF + 100;
    // receiver hold-off that backs the block up into its input
    localparam int PRESSURE_CYCLES = 400;
    // no new random gaps or stalls start once this few items are left to send
    localparam int TAIL_ITEMS      = 60;
    localparam int RANDOM_ITEMS    = 200;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    t_in_item  stim_q[$];
    t_out_item query_results_due[$];

    int n_errors     = 0;
    int n_taken      = 0;
    int n_total      = 0;
    int results_seen = 0;
    int stuck_cycles = 0;

    // predictor copy of the point list and row table
    logic [COL_W-1:0]  pt_col    [MAX_CORNERS_DEF];
    logic [ROW_W-1:0]  pt_row    [MAX_CORNERS_DEF];
    logic [CIDX_W-1:0] row_first [MAX_ROWS_DEF];
    bit                row_on    [MAX_ROWS_DEF];
    int unsigned       n_corners   = 0;
    logic [ROW_W-1:0]  open_row    = '0;
    bit                open_row_ok = 1'b0;

    corner_row_index_rect_query_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor: applies one accepted item to the list and, for a query, queues its end marker after the hits
    // ------------------------------------------------------------------------
    task automatic corner_list_step(input t_in_item it);
        logic [COL_W:0] x_end;
        logic [ROW_W:0] y_end;
        int unsigned    r;
        int unsigned    k;
        int             n_hits;
        bit             cut;
        t_out_item      res;
        case (it.op)
            OP_CLEAR: begin
                foreach (row_on[i]) row_on[i] = 1'b0;
                n_corners   = 0;
                open_row_ok = 1'b0;
            end
            OP_APPEND: begin
                // full list and rows outside the table are dropped
                if (n_corners < MAX_CORNERS_DEF && it.point_y < MAX_ROWS_DEF) begin
                    pt_col[n_corners] = it.point_x;
                    pt_row[n_corners] = it.point_y;
                    // a change of row opens a new row entry, even a row seen before
                    if (!open_row_ok || it.point_y != open_row) begin
                        row_first[it.point_y] = CIDX_W'(n_corners);
                        row_on[it.point_y]    = 1'b1;
                        open_row              = it.point_y;
                        open_row_ok           = 1'b1;
                    end
                    n_corners++;
                end
            end
            OP_QUERY: begin
                // right and bottom edges at full width, no wrap
                x_end  = {1'b0, it.point_x} + it.box_w;
                y_end  = {1'b0, it.point_y} + it.box_h;
                n_hits = 0;
                cut    = 1'b0;
                for (r = it.point_y; r < y_end && r < MAX_ROWS_DEF && !cut; r++) begin
                    if (!row_on[r])
                        continue;
                    k = row_first[r];
                    // skip points of the row left of the box
                    while (k < n_corners && pt_row[k] == r && pt_col[k] < it.point_x)
                        k++;
                    while (k < n_corners && pt_row[k] == r && pt_col[k] < x_end) begin
                        if (n_hits >= MAX_HITS_DEF) begin
                            cut = 1'b1;
                            break;
                        end
                        res.corner_index = CIDX_W'(k);
                        res.hit          = 1'b1;
                        res.last         = 1'b0;
                        res.truncated    = 1'b0;
                        query_results_due = {query_results_due, res};
                        n_hits++;
                        k++;
                    end
                end
                // end marker closes every query
                res.corner_index = '0;
                res.hit          = 1'b0;
                res.last         = 1'b1;
                res.truncated    = cut;
                query_results_due = {query_results_due, res};
            end
            default: begin
                // unknown op, nothing happens
            end
        endcase
    endtask

    task automatic push_item(input t_op op, input int x, input int y, input int w,
                             input int h);
        t_in_item it;
        it.op      = op;
        it.point_x = COL_W'(x);
        it.point_y = ROW_W'(y);
        it.box_w   = COL_W'(w);
        it.box_h   = ROW_W'(h);
        stim_q     = {stim_q, it};
    endtask

    // ------------------------------------------------------------------------
    // driver: offers items from stim_q with random gap bursts
    // ------------------------------------------------------------------------
    int send_gap_left  = 0;
    int send_mode_left = 0;
    bit send_gaps      = 1'b1;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                corner_list_step(in_item);
                n_taken++;
            end
            // re-roll between gappy and gap-free stretches
            if (send_mode_left == 0) begin
                send_gaps      = ($urandom_range(0, 2) != 0);
                send_mode_left = $urandom_range(50, 400);
            end else begin
                send_mode_left--;
            end
            // payload only moves once the current item is gone
            if (!in_valid || !in_stall) begin
                if (send_gap_left > 0) begin
                    send_gap_left--;
                    in_valid <= 1'b0;
                end else if (stim_q.size() > 0) begin
                    in_item  <= stim_q.pop_front();
                    in_valid <= 1'b1;
                    if (send_gaps && stim_q.size() > TAIL_ITEMS &&
                        $urandom_range(0, 5) == 0)
                        send_gap_left = $urandom_range(1, 12);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks each result against the oldest one due, drives stall
    // ------------------------------------------------------------------------
    int        stall_left     = 0;
    int        hold_left      = 0;
    int        recv_mode_left = 0;
    bit        recv_stalls    = 1'b1;
    bit        pressure_done  = 1'b0;
    t_out_item want;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (query_results_due.size() == 0) begin
                    $display("%0t: extra result, expected none, actual %0d/%b/%b/%b",
                             $time, out_item.corner_index, out_item.hit, out_item.last,
                             out_item.truncated);
                    n_errors++;
                end else begin
                    want = query_results_due.pop_front();
                    if (out_item.corner_index !== want.corner_index ||
                        out_item.hit !== want.hit ||
                        out_item.last !== want.last ||
                        out_item.truncated !== want.truncated) begin
                        $display("%0t: mismatch, expected %0d/%b/%b/%b, actual %0d/%b/%b/%b",
                                 $time, want.corner_index, want.hit, want.last,
                                 want.truncated, out_item.corner_index, out_item.hit,
                                 out_item.last, out_item.truncated);
                        n_errors++;
                    end
                end
            end
            if (recv_mode_left == 0) begin
                recv_stalls    = ($urandom_range(0, 2) != 0);
                recv_mode_left = $urandom_range(50, 400);
            end else begin
                recv_mode_left--;
            end
            if (hold_left > 0) begin
                // long hold-off in progress, sender keeps offering
                hold_left--;
                out_stall <= 1'b1;
            end else if (!pressure_done && results_seen >= 40 && out_valid) begin
                pressure_done = 1'b1;
                hold_left     = PRESSURE_CYCLES - 1;
                out_stall    <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (recv_stalls && stim_q.size() > TAIL_ITEMS &&
                         $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 11);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        wait (stuck_cycles >= WATCHDOG_LIMIT);
        $display("tb_top NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int base_count;
        int y0;
        int n_rows;
        int row;
        int n_pts;
        int col;
        int n_q;
        int qx;
        int qy;
        int qw;
        int qh;

        // directed: empty list, field extremes, edges, unsorted rows, clear
        push_item(OP_QUERY, 0, 0, 2047, 1023);           // nothing loaded
        push_item(OP_APPEND, 0, 0, 0, 0);
        push_item(OP_APPEND, 2047, 0, 0, 0);
        push_item(OP_APPEND, 100, 3, 2047, 1023);        // box fields ignored on append
        push_item(OP_APPEND, 200, 3, 0, 0);
        push_item(OP_APPEND, 300, 3, 0, 0);
        push_item(OP_APPEND, 50, 1023, 0, 0);
        push_item(OP_APPEND, 2047, 1023, 0, 0);
        push_item(OP_QUERY, 0, 0, 2047, 1023);           // col 2047 just outside
        push_item(OP_QUERY, 1000, 1000, 2047, 1023);     // box past both edges
        push_item(OP_QUERY, 2047, 1023, 2047, 1023);
        push_item(OP_QUERY, 100, 3, 0, 5);               // zero width
        push_item(OP_QUERY, 100, 3, 500, 0);             // zero height
        push_item(OP_QUERY, 150, 3, 100, 1);             // skip left point
        push_item(OP_QUERY, 0, 500, 2047, 10);           // empty rows only
        push_item(t_op'(2'b11), 2047, 1023, 2047, 1023); // unknown op
        push_item(OP_APPEND, 7, 2, 0, 0);                // rows out of order
        push_item(OP_APPEND, 8, 3, 0, 0);                // row 3 opened again
        push_item(OP_QUERY, 0, 2, 2047, 2);
        push_item(OP_CLEAR, 2047, 1023, 2047, 1023);
        push_item(OP_QUERY, 0, 0, 2047, 1023);           // cleared list

        // dense rows: 70 points on each of rows 10 to 12, more than the hit cap
        push_item(OP_CLEAR, 0, 0, 0, 0);
        for (int r = 10; r < 13; r++)
            for (int i = 0; i < 70; i++)
                push_item(OP_APPEND, i * 29 + $urandom_range(0, 20), r, 0, 0);
        push_item(OP_QUERY, 0, 10, 2047, 1);             // hit cap reached
        push_item(OP_QUERY, 0, 10, 2047, 3);
        push_item(OP_QUERY, 500, 11, 300, 2);
        push_item(OP_QUERY, 1900, 12, 2047, 1);          // right end of a row
        for (int i = 0; i < 6; i++)
            push_item(OP_QUERY, $urandom_range(0, 2047), $urandom_range(8, 14),
                      $urandom_range(0, 400), $urandom_range(0, 4));

        // random: mostly clear, sorted appends, queries around them; some noise
        base_count = stim_q.size();
        while (stim_q.size() - base_count < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
                push_item(t_op'($urandom_range(0, 3)), $urandom_range(0, 2047),
                          $urandom_range(0, 1023), $urandom_range(0, 2047),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                      : $urandom_range(0, 8));
            end else begin
                if ($urandom_range(0, 3) != 0)
                    push_item(OP_CLEAR, $urandom_range(0, 2047), $urandom_range(0, 1023),
                              $urandom_range(0, 2047), $urandom_range(0, 1023));
                y0     = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                     : $urandom_range(0, 60);
                n_rows = $urandom_range(1, 6);
                row    = y0;
                for (int rr = 0; rr < n_rows && row <= 1023; rr++) begin
                    n_pts = $urandom_range(0, 12);
                    col   = $urandom_range(0, 300);
                    for (int p = 0; p < n_pts; p++) begin
                        push_item(OP_APPEND, col, row, $urandom_range(0, 2047),
                                  $urandom_range(0, 1023));
                        col = col + $urandom_range(0, 400);
                        if (col > 2047)
                            col = 2047;
                    end
                    row = row + $urandom_range(1, 3);
                end
                n_q = $urandom_range(1, 4);
                for (int q = 0; q < n_q; q++) begin
                    qy = y0 - $urandom_range(0, 2);
                    if (qy < 0)
                        qy = 0;
                    case ($urandom_range(0, 3))
                        0:       qx = 0;
                        1:       qx = $urandom_range(0, 2047);
                        default: qx = $urandom_range(0, 800);
                    endcase
                    case ($urandom_range(0, 4))
                        0:       qw = 2047;
                        1:       qw = $urandom_range(0, 2047);
                        default: qw = $urandom_range(0, 600);
                    endcase
                    qh = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1023)
                                                      : $urandom_range(0, n_rows * 3 + 2);
                    push_item(OP_QUERY, qx, qy, qw, qh);
                end
            end
        end
        n_total = stim_q.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (n_taken < n_total)
            @(posedge clk);
        while (query_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (n_errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
